/* hdl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and round functions for the SHA-256 hasher
// holds the queue entry type, the initial hash value, the round constant
// table and the sigma functions used by the compression datapath
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  localparam int QueueDepth = 16;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [5:0] LengthPos   = 6'd56;
  localparam logic [5:0] LastPos     = 6'd63;
  localparam logic [5:0] ScheduleLen = 6'd16;
  localparam logic [5:0] LastRound   = 6'd63;
  localparam logic [7:0] PadMark     = 8'h80;
  localparam logic [7:0] PadZero     = 8'h00;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  // one message word handed from the front to the back
  typedef struct packed {
    word_t word;
    logic  final_blk;
  } word_req_t;

  localparam hash_t InitHash = '{
    0: 32'h6a09e667, 1: 32'hbb67ae85, 2: 32'h3c6ef372, 3: 32'ha54ff53a,
    4: 32'h510e527f, 5: 32'h9b05688c, 6: 32'h1f83d9ab, 7: 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

/* hdl/sha_queue.sv */
// ----------------------------------------------------------------------------
// sha_queue: message word queue between front and back
// small first-word-fall-through queue of word requests
// ----------------------------------------------------------------------------
`default_nettype none

module sha_queue
  import sha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_en,
  input  wire word_req_t wr_data,
  output logic           q_full,
  input  wire logic      rd_en,
  output word_req_t      rd_data,
  output logic           q_empty
);

  word_req_t             entries [QueueDepth];
  logic [QueueAw-1:0]    wr_ptr;
  logic [QueueAw-1:0]    rd_ptr;
  logic [QueueAw:0]      count;

  assign q_full  = (count == (QueueAw+1)'(QueueDepth));
  assign q_empty = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/sha_front.sv */
// ----------------------------------------------------------------------------
// sha_front: byte intake and padding
// packs message bytes into words, appends the end mark, zero fill and bit
// length, and queues each completed word for compression
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front
  import sha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] byte_value,
  input  wire logic       has_byte,
  input  wire logic       end_of_message,
  input  wire logic       push,
  output logic            full,
  input  wire logic       q_full,
  output logic            q_push,
  output word_req_t       q_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MARK = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_LEN  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  fill;
  logic [23:0] word_acc;
  logic [63:0] message_bits;
  logic [2:0]  len_idx;

  logic        accept;
  logic        ins_en;
  logic [7:0]  ins_byte;
  logic        ins_final;

  assign full   = (state != ST_IDLE) || q_full;
  assign accept = push && !full;

  always_comb begin
    ins_en    = 1'b0;
    ins_byte  = PadZero;
    ins_final = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && has_byte) begin
          ins_en   = 1'b1;
          ins_byte = byte_value;
        end
      end
      ST_MARK: begin
        ins_en   = !q_full;
        ins_byte = PadMark;
      end
      ST_ZERO: begin
        ins_en = !q_full && (fill != LengthPos);
      end
      ST_LEN: begin
        ins_en    = !q_full;
        ins_byte  = message_bits[63:56];
        ins_final = (len_idx == 3'd7);
      end
    endcase
  end

  // a word leaves whenever its fourth byte goes in
  assign q_push          = ins_en && (fill[1:0] == 2'b11);
  assign q_data.word     = {word_acc, ins_byte};
  assign q_data.final_blk = ins_final;

  always_ff @(posedge clk) begin
    if (ins_en) begin
      word_acc <= {word_acc[15:0], ins_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      message_bits <= '0;
      len_idx      <= '0;
    end else begin
      if (ins_en) begin
        fill <= fill + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && has_byte) begin
            message_bits <= message_bits + 64'd8;
          end
          if (accept && end_of_message) begin
            state <= ST_MARK;
          end
        end
        ST_MARK: begin
          if (!q_full) begin
            state <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (fill == LengthPos) begin
            state   <= ST_LEN;
            len_idx <= '0;
          end
        end
        ST_LEN: begin
          // length goes out msb first; the shift leaves the count at zero
          if (ins_en) begin
            message_bits <= {message_bits[55:0], 8'h00};
            len_idx      <= len_idx + 1'b1;
            if (len_idx == 3'd7) begin
              state <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/sha_back.sv */
// ----------------------------------------------------------------------------
// sha_back: compression engine and digest output
// one round per cycle, stalling in rounds 0..15 while the queue is empty, with a
// sliding message schedule; after the final block of a message the digest is
// shifted out one word per request
`default_nettype none

module sha_back
  import sha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_empty,
  input  wire word_req_t q_data,
  output logic           q_pop,
  output logic           empty,
  input  wire logic      pop,
  output logic [2:0]     word_index,
  output logic [31:0]    digest_word,
  output logic           last_word
);

  localparam logic B_RUN = 1'b0;
  localparam logic B_ADD = 1'b1;

  logic        bstate;
  logic [5:0]  round;
  hash_t       hash;
  hash_t       v;
  word_t [15:0] win;
  logic        final_blk;
  hash_t       dig;
  logic        out_busy;
  logic [2:0]  out_idx;

  logic        need_word;
  logic        step;
  logic        add_go;
  word_t       wt;
  word_t       ch;
  word_t       maj;
  word_t       t1;
  word_t       t2;
  hash_t       hsum;

  assign need_word = (round < ScheduleLen);
  assign q_pop     = (bstate == B_RUN) && need_word && !q_empty;
  assign step      = (bstate == B_RUN) && (!need_word || !q_empty);
  assign add_go    = (bstate == B_ADD) && !(final_blk && out_busy);

  always_comb begin
    if (need_word) begin
      wt = q_data.word;
    end else begin
      wt = win[0] + small_sigma0(win[1]) + win[9] + small_sigma1(win[14]);
    end
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + big_sigma1(v[4]) + ch + round_k(round) + wt;
    t2  = big_sigma0(v[0]) + maj;
    for (int i = 0; i < 8; i++) begin
      hsum[i] = hash[i] + v[i];
    end
  end

  assign empty       = !out_busy;
  assign digest_word = dig[0];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  // datapath registers
  always_ff @(posedge clk) begin
    if (step) begin
      win <= {wt, win[15:1]};
    end
    if (pop && out_busy) begin
      dig <= {word_t'(0), dig[7:1]};
    end
    if (add_go && final_blk) begin
      dig <= hsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_RUN;
      round     <= '0;
      hash      <= InitHash;
      v         <= InitHash;
      final_blk <= 1'b0;
      out_busy  <= 1'b0;
      out_idx   <= '0;
    end else begin
      if (pop && out_busy) begin
        out_idx <= out_idx + 1'b1;
        if (out_idx == 3'd7) begin
          out_busy <= 1'b0;
        end
      end
      unique case (bstate)
        B_RUN: begin
          if (step) begin
            v <= {v[6], v[5], v[4], v[3] + t1, v[2], v[1], v[0], t1 + t2};
            if (q_pop && (round == ScheduleLen - 6'd1)) begin
              final_blk <= q_data.final_blk;
            end
            round <= round + 1'b1;
            if (round == LastRound) begin
              bstate <= B_ADD;
            end
          end
        end
        B_ADD: begin
          if (add_go) begin
            bstate <= B_RUN;
            if (final_blk) begin
              hash     <= InitHash;
              v        <= InitHash;
              out_busy <= 1'b1;
              out_idx  <= '0;
            end else begin
              hash <= hsum;
              v    <= hsum;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher: streaming SHA-256 over a byte stream
// end of message: the front appends the end mark, zero fill and bit length,
//   then the back runs rounds 15 to 63 and the final add from the last
//   length word to the first digest word
// throughput: one byte per cycle into the word packer while full is low; the
//   round engine takes each 64-byte block through its rounds and a final add
// reset: synchronous, clears queue, counters and output; hash reloads the IV
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request side
  input  wire logic [7:0]  byte_value,
  input  wire logic        has_byte,
  input  wire logic        end_of_message,
  input  wire logic        push,
  output logic             full,
  // digest side
  output logic [2:0]       word_index,
  output logic [31:0]      digest_word,
  output logic             last_word,
  output logic             empty,
  input  wire logic        pop
);

  // front to queue
  logic      q_push;
  word_req_t q_wr_data;
  logic      q_full;

  // queue to back
  logic      q_pop;
  word_req_t q_rd_data;
  logic      q_empty;

  // front: accepts requests, counts message bits, packs bytes into big-endian
  // words and, on the end mark, appends 0x80, zero fill and the bit length
  sha_front u_front (
    .clk            (clk),
    .rst            (rst),
    .byte_value     (byte_value),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .push           (push),
    .full           (full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wr_data)
  );

  // sixteen words of slack: the front can load a whole next block while the
  // back spends rounds 16..63 on the current one
  sha_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  // back: rounds 0..15 take their schedule word straight from the queue,
  // rounds 16..63 compute it from a 16-word window; the final block of a
  // message parks the digest in an output shift register and reloads the IV
  sha_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .word_index  (word_index),
    .digest_word (digest_word),
    .last_word   (last_word)
  );

`ifndef SYNTHESIS
  // front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("word queue overflow");

  // back never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("word queue underflow");

  // taking the last digest word drains the output before the next digest
  a_digest_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_word) |=> empty)
    else $error("digest output not drained after last word");

  // an accepted request always finds room for the word it may complete
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !q_full)
    else $error("request accepted with queue full");
`endif

endmodule

`default_nettype wire
